// ----- sv/pol_pkg.sv -----
// types, character codes and token kinds shared by the punctuation lexer
`timescale 1ns / 1ps
`default_nettype none

package pol_pkg;

	// token kinds, in scanner order
	localparam logic [4:0] TK_LPAREN   = 5'd0;
	localparam logic [4:0] TK_RPAREN   = 5'd1;
	localparam logic [4:0] TK_LBRACE   = 5'd2;
	localparam logic [4:0] TK_RBRACE   = 5'd3;
	localparam logic [4:0] TK_COMMA    = 5'd4;
	localparam logic [4:0] TK_DOT      = 5'd5;
	localparam logic [4:0] TK_MINUS    = 5'd6;
	localparam logic [4:0] TK_PLUS     = 5'd7;
	localparam logic [4:0] TK_SEMI     = 5'd8;
	localparam logic [4:0] TK_STAR     = 5'd9;
	localparam logic [4:0] TK_BANG_EQ  = 5'd10;
	localparam logic [4:0] TK_BANG     = 5'd11;
	localparam logic [4:0] TK_EQ_EQ    = 5'd12;
	localparam logic [4:0] TK_EQUAL    = 5'd13;
	localparam logic [4:0] TK_GT_EQ    = 5'd14;
	localparam logic [4:0] TK_GT       = 5'd15;
	localparam logic [4:0] TK_LT_EQ    = 5'd16;
	localparam logic [4:0] TK_LT       = 5'd17;
	localparam logic [4:0] TK_SLASH    = 5'd18;
	localparam logic [4:0] TK_EOF      = 5'd19;
	localparam logic [4:0] TK_ERROR    = 5'd20;

	// source characters
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;

	localparam logic [15:0] SAT16 = 16'hFFFF;

	// character held for one byte of lookahead
	typedef enum logic [2:0] {
		PEND_NONE  = 3'd0,
		PEND_BANG  = 3'd1,
		PEND_EQUAL = 3'd2,
		PEND_GT    = 3'd3,
		PEND_LT    = 3'd4,
		PEND_SLASH = 3'd5
	} pend_t;

	typedef struct packed {
		logic [4:0]  tk_kind;
		logic [15:0] tk_line;
		logic [15:0] tk_start;
		logic [1:0]  tk_len;
		logic        tk_last;
	} token_t;

	function automatic logic [4:0] single_kind(input pend_t p);
		logic [4:0] k;
		case (p)
			PEND_BANG:  k = TK_BANG;
			PEND_EQUAL: k = TK_EQUAL;
			PEND_GT:    k = TK_GT;
			PEND_LT:    k = TK_LT;
			PEND_SLASH: k = TK_SLASH;
			default:    k = TK_ERROR;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] eq_kind(input pend_t p);
		logic [4:0] k;
		case (p)
			PEND_BANG:  k = TK_BANG_EQ;
			PEND_EQUAL: k = TK_EQ_EQ;
			PEND_GT:    k = TK_GT_EQ;
			PEND_LT:    k = TK_LT_EQ;
			default:    k = TK_ERROR;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

// ----- sv/punctuation_operator_lexer.sv -----
// top level of the punctuation and operator lexer
`timescale 1ns / 1ps
`default_nettype none

// Lexes one source byte per clock while in_ready is high. Each accepted item is
// decoded in the cycle it arrives against the lookahead state and gives zero,
// one or two tokens into a three-entry result queue. The input side is ready
// while at most one token waits, so a stream of up to one token per byte runs at
// one item per cycle while out_ready holds; an item that yields two tokens (held
// character flushed ahead of another token, or ahead of the end-of-file token)
// needs two output turns. first_line is to be written through cfg_wr_en /
// cfg_wr_data only while the lexer is idle; the block does not enforce this.
module punctuation_operator_lexer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [7:0]  char_code,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [4:0]       token_kind,
	output logic [15:0]      line_number,
	output logic [15:0]      start_offset,
	output logic [1:0]       lexeme_length,
	output logic             last_of_run
);
	import pol_pkg::*;

	localparam int unsigned QDEPTH = 3;

	logic [15:0] first_line_q;
	pend_t       pend_q, pend_d;
	logic [15:0] pstart_q, pstart_d;
	logic        comment_q, comment_d;
	logic [15:0] line_q, line_d;
	logic [15:0] pos_q, pos_d;

	token_t      fifo_q [QDEPTH];
	logic [1:0]  wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;

	token_t      tok_a, tok_b, first_tok;
	logic        a_v, b_v;
	logic [4:0]  byte_kind;
	logic        eq_match;
	logic [1:0]  push_n;
	logic        accept, pop;

	function automatic logic [1:0] ptr_inc(input logic [1:0] p);
		return (p == 2'(QDEPTH - 1)) ? 2'd0 : p + 2'd1;
	endfunction

	assign in_ready = (count_q <= 2'd1);
	assign accept   = in_valid && in_ready;
	assign out_valid = (count_q != 2'd0);
	assign pop      = out_valid && out_ready;

	assign eq_match = (pend_q == PEND_BANG || pend_q == PEND_EQUAL ||
		pend_q == PEND_GT || pend_q == PEND_LT) && (char_code == CH_EQUAL);

	always_comb begin
		a_v       = 1'b0;
		b_v       = 1'b0;
		byte_kind = TK_ERROR;
		pend_d    = pend_q;
		pstart_d  = pstart_q;
		comment_d = comment_q;
		line_d    = line_q;
		pos_d     = pos_q;
		// flush of the held character, used by several branches
		tok_a     = '{tk_kind: single_kind(pend_q), tk_line: line_q, tk_start: pstart_q,
			tk_len: 2'd1, tk_last: 1'b0};
		tok_b     = '{tk_kind: TK_EOF, tk_line: line_q, tk_start: pos_q,
			tk_len: 2'd0, tk_last: 1'b1};
		if (kind) begin
			a_v       = (pend_q != PEND_NONE);
			b_v       = 1'b1;
			pend_d    = PEND_NONE;
			pstart_d  = '0;
			comment_d = 1'b0;
			line_d    = first_line_q;
			pos_d     = '0;
		end else begin
			if (pos_q != SAT16) begin
				pos_d = pos_q + 16'd1;
			end
			if (eq_match) begin
				a_v    = 1'b1;
				tok_a  = '{tk_kind: eq_kind(pend_q), tk_line: line_q, tk_start: pstart_q,
					tk_len: 2'd2, tk_last: 1'b0};
				pend_d = PEND_NONE;
			end else if (pend_q == PEND_SLASH && char_code == CH_SLASH) begin
				pend_d    = PEND_NONE;
				comment_d = 1'b1;
			end else begin
				a_v    = (pend_q != PEND_NONE);
				pend_d = PEND_NONE;
				if (comment_q) begin
					if (char_code == CH_NL) begin
						comment_d = 1'b0;
						if (line_q != SAT16) begin
							line_d = line_q + 16'd1;
						end
					end
				end else begin
					case (char_code)
						CH_LPAREN: begin b_v = 1'b1; byte_kind = TK_LPAREN; end
						CH_RPAREN: begin b_v = 1'b1; byte_kind = TK_RPAREN; end
						CH_LBRACE: begin b_v = 1'b1; byte_kind = TK_LBRACE; end
						CH_RBRACE: begin b_v = 1'b1; byte_kind = TK_RBRACE; end
						CH_COMMA:  begin b_v = 1'b1; byte_kind = TK_COMMA; end
						CH_DOT:    begin b_v = 1'b1; byte_kind = TK_DOT; end
						CH_MINUS:  begin b_v = 1'b1; byte_kind = TK_MINUS; end
						CH_PLUS:   begin b_v = 1'b1; byte_kind = TK_PLUS; end
						CH_SEMI:   begin b_v = 1'b1; byte_kind = TK_SEMI; end
						CH_STAR:   begin b_v = 1'b1; byte_kind = TK_STAR; end
						CH_BANG:   begin pend_d = PEND_BANG;  pstart_d = pos_q; end
						CH_EQUAL:  begin pend_d = PEND_EQUAL; pstart_d = pos_q; end
						CH_GT:     begin pend_d = PEND_GT;    pstart_d = pos_q; end
						CH_LT:     begin pend_d = PEND_LT;    pstart_d = pos_q; end
						CH_SLASH:  begin pend_d = PEND_SLASH; pstart_d = pos_q; end
						CH_SPACE, CH_CR, CH_TAB: begin end
						CH_NL: begin
							if (line_q != SAT16) begin
								line_d = line_q + 16'd1;
							end
						end
						default: begin b_v = 1'b1; byte_kind = TK_ERROR; end
					endcase
				end
				tok_b = '{tk_kind: byte_kind, tk_line: line_q, tk_start: pos_q,
					tk_len: 2'd1, tk_last: 1'b1};
			end
		end
		tok_a.tk_last = !b_v;
	end

	assign first_tok = a_v ? tok_a : tok_b;
	assign push_n    = {1'b0, a_v} + {1'b0, b_v};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_line_q <= 16'd1;
			pend_q       <= PEND_NONE;
			pstart_q     <= '0;
			comment_q    <= 1'b0;
			line_q       <= 16'd1;
			pos_q        <= '0;
		end else begin
			if (cfg_wr_en) begin
				first_line_q <= cfg_wr_data;
			end
			if (accept) begin
				pend_q    <= pend_d;
				pstart_q  <= pstart_d;
				comment_q <= comment_d;
				line_q    <= line_d;
				pos_q     <= pos_d;
			end else if (cfg_wr_en && pos_q == '0 && pend_q == PEND_NONE && !comment_q) begin
				// at the start of a text the new first line applies at once
				line_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (a_v || b_v)) begin
			fifo_q[wr_ptr_q] <= first_tok;
		end
		if (accept && a_v && b_v) begin
			fifo_q[ptr_inc(wr_ptr_q)] <= tok_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				case (push_n)
					2'd1:    wr_ptr_q <= ptr_inc(wr_ptr_q);
					2'd2:    wr_ptr_q <= ptr_inc(ptr_inc(wr_ptr_q));
					default: wr_ptr_q <= wr_ptr_q;
				endcase
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + (accept ? push_n : 2'd0) - {1'b0, pop};
		end
	end

	assign token_kind    = fifo_q[rd_ptr_q].tk_kind;
	assign line_number   = fifo_q[rd_ptr_q].tk_line;
	assign start_offset  = fifo_q[rd_ptr_q].tk_start;
	assign lexeme_length = fifo_q[rd_ptr_q].tk_len;
	assign last_of_run   = fifo_q[rd_ptr_q].tk_last;

endmodule

`default_nettype wire

// ----- sv/pol_checker.sv -----
// port-level checks for the punctuation lexer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module pol_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        kind,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [4:0]  token_kind,
	input wire logic [15:0] line_number,
	input wire logic [15:0] start_offset,
	input wire logic [1:0]  lexeme_length,
	input wire logic        last_of_run
);
	import pol_pkg::*;

	// a stalled token holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_kind) &&
		$stable(line_number) && $stable(start_offset) && $stable(lexeme_length) &&
		$stable(last_of_run))
		else $error("stalled token changed");

	// no token shows up without an item behind it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && in_ready) && !out_valid |=> !out_valid)
		else $error("token without an item");

	// an end item always yields an end-of-file token
	a_end_token: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind |=> out_valid)
		else $error("end item gave no token");

	// end-of-file tokens are empty and close their run
	a_eof_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == TK_EOF |-> lexeme_length == 2'd0 && last_of_run)
		else $error("malformed end-of-file token");

	// two-character operators carry length two
	a_pair_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_kind == TK_BANG_EQ || token_kind == TK_EQ_EQ ||
		token_kind == TK_GT_EQ || token_kind == TK_LT_EQ) |-> lexeme_length == 2'd2)
		else $error("operator pair with wrong length");

endmodule

bind punctuation_operator_lexer pol_checker u_pol_checker (.*);

`default_nettype wire

// ----- tb/testbench.sv -----
// self-checking bench for the punctuation and operator lexer
`timescale 1ns / 1ps

module testbench;
	import pol_pkg::*;

	localparam logic IN_BYTE = 1'b0;
	localparam logic IN_END  = 1'b1;
	localparam int   MAX_GAP = 18;
	localparam int   SETTLE  = 4;

	// tracks the lexer state and the tokens still owed by the block
	class token_tracker;
		token_t      tokens_due[$];
		int          mismatch_count;
		logic [15:0] first_line_val;
		logic [15:0] cur_line;
		logic [15:0] pos;
		logic [15:0] held_at;
		pend_t       held;
		bit          in_cmt;

		function new();
			mismatch_count = 0;
			first_line_val = 16'd1;
			restart();
		endfunction

		function void restart();
			held = PEND_NONE;
			held_at = '0;
			in_cmt = 1'b0;
			cur_line = first_line_val;
			pos = '0;
		endfunction

		function int pending();
			return tokens_due.size();
		endfunction

		function void push_token(logic [4:0] k, logic [15:0] start, logic [1:0] len);
			token_t t;
			t.tk_kind = k;
			t.tk_line = cur_line;
			t.tk_start = start;
			t.tk_len = len;
			t.tk_last = 1'b0;
			tokens_due.insert(tokens_due.size(), t);
		endfunction

		function void bump_line();
			if (cur_line != SAT16)
				cur_line++;
		endfunction

		function void set_first_line(logic [15:0] v);
			first_line_val = v;
			// only a text that has not started picks the value up at once
			if (pos == '0 && held == PEND_NONE && !in_cmt)
				cur_line = v;
		endfunction

		function void flush_held();
			case (held)
				PEND_BANG:  push_token(TK_BANG, held_at, 2'd1);
				PEND_EQUAL: push_token(TK_EQUAL, held_at, 2'd1);
				PEND_GT:    push_token(TK_GT, held_at, 2'd1);
				PEND_LT:    push_token(TK_LT, held_at, 2'd1);
				PEND_SLASH: push_token(TK_SLASH, held_at, 2'd1);
				default: ;
			endcase
			held = PEND_NONE;
		endfunction

		function void hold(pend_t p, logic [15:0] off);
			held = p;
			held_at = off;
		endfunction

		function void take_byte(logic [7:0] c, logic [15:0] off);
			if (in_cmt) begin
				if (c == CH_NL) begin
					in_cmt = 1'b0;
					bump_line();
				end
			end else begin
				case (c)
					CH_LPAREN: push_token(TK_LPAREN, off, 2'd1);
					CH_RPAREN: push_token(TK_RPAREN, off, 2'd1);
					CH_LBRACE: push_token(TK_LBRACE, off, 2'd1);
					CH_RBRACE: push_token(TK_RBRACE, off, 2'd1);
					CH_COMMA:  push_token(TK_COMMA, off, 2'd1);
					CH_DOT:    push_token(TK_DOT, off, 2'd1);
					CH_MINUS:  push_token(TK_MINUS, off, 2'd1);
					CH_PLUS:   push_token(TK_PLUS, off, 2'd1);
					CH_SEMI:   push_token(TK_SEMI, off, 2'd1);
					CH_STAR:   push_token(TK_STAR, off, 2'd1);
					CH_BANG:   hold(PEND_BANG, off);
					CH_EQUAL:  hold(PEND_EQUAL, off);
					CH_GT:     hold(PEND_GT, off);
					CH_LT:     hold(PEND_LT, off);
					CH_SLASH:  hold(PEND_SLASH, off);
					CH_SPACE, CH_CR, CH_TAB: ;
					CH_NL:     bump_line();
					default:   push_token(TK_ERROR, off, 2'd1);
				endcase
			end
		endfunction

		function void note_item(logic k, logic [7:0] c);
			int          before_n;
			logic [15:0] off;
			before_n = tokens_due.size();
			if (k == IN_END) begin
				flush_held();
				push_token(TK_EOF, pos, 2'd0);
				restart();
			end else begin
				off = pos;
				if (pos != SAT16)
					pos++;
				if (c == CH_EQUAL && held != PEND_NONE && held != PEND_SLASH) begin
					case (held)
						PEND_BANG:  push_token(TK_BANG_EQ, held_at, 2'd2);
						PEND_EQUAL: push_token(TK_EQ_EQ, held_at, 2'd2);
						PEND_GT:    push_token(TK_GT_EQ, held_at, 2'd2);
						default:    push_token(TK_LT_EQ, held_at, 2'd2);
					endcase
					held = PEND_NONE;
				end else if (held == PEND_SLASH && c == CH_SLASH) begin
					held = PEND_NONE;
					in_cmt = 1'b1;
				end else begin
					flush_held();
					take_byte(c, off);
				end
			end
			if (tokens_due.size() > before_n)
				tokens_due[tokens_due.size() - 1].tk_last = 1'b1;
		endfunction

		function void report(string what, int unsigned want, int unsigned got);
			mismatch_count++;
			$display("%0t %s: expected %0d actual %0d", $time, what, want, got);
		endfunction

		function void compare(string what, int unsigned want, int unsigned got);
			if (want != got)
				report(what, want, got);
		endfunction

		function void check_token(token_t got);
			token_t want;
			if (tokens_due.size() == 0) begin
				report("token with none due, kind", 0, got.tk_kind);
			end else begin
				want = tokens_due.pop_front();
				compare("token_kind", want.tk_kind, got.tk_kind);
				compare("line_number", want.tk_line, got.tk_line);
				compare("start_offset", want.tk_start, got.tk_start);
				compare("lexeme_length", want.tk_len, got.tk_len);
				compare("last_of_run", want.tk_last, got.tk_last);
			end
		endfunction

		function void check_drained();
			if (tokens_due.size() != 0)
				report("tokens still due", 0, tokens_due.size());
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	logic        in_valid;
	logic        in_ready;
	logic        kind;
	logic [7:0]  char_code;
	logic        out_valid;
	logic        out_ready;
	logic [4:0]  token_kind;
	logic [15:0] line_number;
	logic [15:0] start_offset;
	logic [1:0]  lexeme_length;
	logic        last_of_run;

	token_tracker tracker = new();

	bit tx_no_gap = 1'b0;
	bit rx_no_stall = 1'b0;
	int tx_burst = 0;
	int rx_burst = 0;
	int items_sent = 0;

	logic [7:0] singles[10] = '{CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_COMMA,
		CH_DOT, CH_MINUS, CH_PLUS, CH_SEMI, CH_STAR};
	logic [7:0] holders[5] = '{CH_BANG, CH_EQUAL, CH_GT, CH_LT, CH_SLASH};
	logic [7:0] blanks[3] = '{CH_SPACE, CH_TAB, CH_CR};
	logic [15:0] line_values[5] = '{16'd0, 16'hFFFF, 16'd1, 16'd65534, 16'd1000};

	punctuation_operator_lexer DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.char_code    (char_code),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.token_kind   (token_kind),
		.line_number  (line_number),
		.start_offset (start_offset),
		.lexeme_length(lexeme_length),
		.last_of_run  (last_of_run)
	);

	always #5 clk = ~clk;

	// idle cycles before the next item, with stretches of none
	function automatic int draw_gap(inout int burst);
		int gap;
		if (burst > 0) begin
			burst--;
			gap = 0;
		end else if ($urandom_range(0, 15) == 0) begin
			burst = $urandom_range(10, 60);
			gap = 0;
		end else begin
			gap = $urandom_range(0, MAX_GAP);
		end
		return gap;
	endfunction

	function automatic logic [7:0] pick_char();
		int r;
		logic [7:0] c;
		r = $urandom_range(0, 99);
		if (r < 30)
			c = singles[$urandom_range(0, 9)];
		else if (r < 55)
			c = holders[$urandom_range(0, 3)];
		else if (r < 65)
			c = CH_EQUAL;
		else if (r < 72)
			c = CH_SLASH;
		else if (r < 80)
			c = blanks[$urandom_range(0, 2)];
		else if (r < 86)
			c = CH_NL;
		else
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	// called at a falling edge, returns at a falling edge with valid still high
	task automatic send_item(input logic k, input logic [7:0] c);
		int gap;
		gap = tx_no_gap ? 0 : draw_gap(tx_burst);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		kind = k;
		char_code = c;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		tracker.note_item(k, c);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(IN_BYTE, s[i]);
	endtask

	// hold off the sender until every token owed has come out
	task automatic wait_idle();
		in_valid = 1'b0;
		while (tracker.pending() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_first_line(input logic [15:0] v);
		wait_idle();
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		@(posedge clk);
		tracker.set_first_line(v);
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// result side
	initial begin
		token_t got;
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = rx_no_stall ? 0 : draw_gap(rx_burst);
			if (gap > 0) begin
				out_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			got.tk_kind = token_kind;
			got.tk_line = line_number;
			got.tk_start = start_offset;
			got.tk_len = lexeme_length;
			got.tk_last = last_of_run;
			tracker.check_token(got);
			@(negedge clk);
		end
	end

	initial begin
		#15_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int r;
		int n;
		int next_cfg;
		int cfg_step;
		int waited;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		kind = IN_BYTE;
		char_code = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// every punctuation mark, the pairs, a held char before a token and a blank,
		// a comment ending at a newline, error bytes, and a held char flushed by the end
		send_text("(){},.-+;*!===>=<=!(/ //a\n\t\r");
		send_item(IN_BYTE, 8'h00);
		send_item(IN_BYTE, 8'hFF);
		send_item(IN_BYTE, CH_LT);
		send_item(IN_END, 8'h00);

		// line counter runs into its ceiling
		write_first_line(16'd65534);
		send_text("\n\n\n;");
		send_item(IN_END, 8'hFF);

		// a text at full rate with no stalls on either side
		write_first_line(16'd7);
		tx_no_gap = 1'b1;
		rx_no_stall = 1'b1;
		repeat (300) send_item(IN_BYTE, pick_char());
		send_text("(<=!;\n>");
		send_item(IN_END, 8'h00);
		wait_idle();
		tx_no_gap = 1'b0;
		rx_no_stall = 1'b0;

		cfg_step = 0;
		next_cfg = items_sent + 150;
		while (items_sent < 1100) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				send_item(IN_END, 8'($urandom_range(0, 255)));
			end else if (r < 7) begin
				// comment with arbitrary contents
				send_text("//");
				n = $urandom_range(0, 6);
				repeat (n) send_item(IN_BYTE, 8'($urandom_range(0, 255)));
				send_item(IN_BYTE, CH_NL);
			end else begin
				send_item(IN_BYTE, pick_char());
			end
			if (items_sent >= next_cfg) begin
				if (cfg_step < 5)
					write_first_line(line_values[cfg_step]);
				else
					write_first_line(16'($urandom_range(0, 65535)));
				cfg_step++;
				next_cfg = items_sent + $urandom_range(100, 200);
			end
		end
		send_item(IN_END, 8'h00);

		in_valid = 1'b0;
		waited = 0;
		while (tracker.pending() > 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		tracker.check_drained();
		if (tracker.mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/pol_pkg.sv
sv/punctuation_operator_lexer.sv
sv/pol_checker.sv
tb/testbench.sv
